FILE: rtl/rde_pkg.sv
// Shared types, constants and helper functions for the radix digit emitter.
// Used by rde_front, rde_back and radix_digit_emitter; depends on nothing else.
package rde_pkg;

  // Field and register widths.
  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CFG_DW    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CHARS = 16;

  // Largest base the character table supports.
  localparam int MAX_RADIX = 16;

  // Default for the digit count limit.
  localparam int MAX_DIGITS_DEF = 32;

  // The divider retires one byte of the dividend per cycle.
  localparam int STEP_BITS     = 8;
  localparam int STEPS_PER_DIG = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W    = $clog2(STEPS_PER_DIG);

  // Input word queue between front and back.
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  // Reset values of the configuration registers.
  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd16;
  localparam logic [CFG_DW-1:0]  CHARS_LO_RST = 64'h3736353433323130;
  localparam logic [CFG_DW-1:0]  CHARS_HI_RST = 64'h6665646362613938;

  // Characters that may not appear in the table.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_CHARS_LO = 2'd1,
    REG_CHARS_HI = 2'd2
  } cfg_idx_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_t;

  // Current configuration as seen by front and back.
  typedef struct packed {
    logic [RADIX_W-1:0]              radix;
    logic [NUM_CHARS-1:0][CHAR_W-1:0] chars;
  } cfg_t;

  // Head word of the queue offered to the back end.
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
  } fe_item_t;

  // Back end status for checking at the top level.
  typedef struct packed {
    bk_state_t          state;
    logic [DIGIT_W-1:0] rem;
    logic               cnt_zero;
  } bk_stat_t;

  // The table is usable when the base is in range and every entry in use is
  // a legal, distinct character.
  function automatic logic table_ok(cfg_t c);
    logic ok;
    ok = (c.radix >= 5'd2) && (c.radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (RADIX_W'(i) < c.radix) begin
        if (c.chars[i] == CH_NUL || c.chars[i] == CH_PLUS || c.chars[i] == CH_MINUS) begin
          ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (c.chars[j] == c.chars[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

FILE: rtl/rde_front.sv
// Front end of the radix digit emitter: accepts words, drops them when the
// character table is unusable, and queues the rest. Depends on rde_pkg.
module rde_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rde_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rde_pkg::VALUE_W-1:0] in_value,
  output rde_pkg::fe_item_t           item,
  input  logic                        pop
);

  logic [rde_pkg::VALUE_W-1:0] q_mem_r [rde_pkg::QDEPTH];
  logic [rde_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [rde_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [rde_pkg::QCNT_W-1:0]  q_cnt_r, q_cnt_nxt;
  logic                        tbl_ok;
  logic                        push;
  logic                        do_pop;

  // Classify: a word is kept only when the table is usable.
  assign tbl_ok   = rde_pkg::table_ok(cfg);
  assign in_stall = (q_cnt_r == rde_pkg::QCNT_W'(rde_pkg::QDEPTH));
  assign push     = in_valid && !in_stall && tbl_ok;
  assign do_pop   = pop && (q_cnt_r != '0);

  // Queue head offered to the back end.
  assign item.vld   = (q_cnt_r != '0);
  assign item.value = q_mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !do_pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

FILE: rtl/rde_back.sv
// Back end of the radix digit emitter: divides by the base one byte of
// dividend per cycle, buffers the digits and emits characters MSB first.
// Depends on rde_pkg.
module rde_back #(
  parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rde_pkg::cfg_t              cfg,
  input  rde_pkg::fe_item_t          item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rde_pkg::CHAR_W-1:0] out_character,
  output logic                       out_last_digit,
  output rde_pkg::bk_stat_t          stat
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  rde_pkg::bk_state_t               st_r, st_nxt;
  logic [rde_pkg::VALUE_W-1:0]      div_r, div_nxt;
  logic [rde_pkg::DIGIT_W-1:0]      rem_r, rem_nxt;
  logic [rde_pkg::STEP_CNT_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [rde_pkg::CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                             out_last_r, out_last_nxt;
  logic [rde_pkg::DIGIT_W-1:0]      buf_r [MAX_DIGITS];
  logic                             buf_we;
  logic [CNT_W-1:0]                 cnt_m1;
  logic [rde_pkg::STEP_BITS-1:0]    step_q;
  logic [rde_pkg::DIGIT_W-1:0]      step_rem;
  logic [rde_pkg::VALUE_W-1:0]      quot_next;

  // Eight restoring division steps on the top byte of the dividend.
  always_comb begin : div_step
    logic [rde_pkg::DIGIT_W:0] t;
    logic [rde_pkg::DIGIT_W-1:0] r;
    r      = rem_r;
    step_q = '0;
    for (int k = 0; k < rde_pkg::STEP_BITS; k++) begin
      t = {r, div_r[rde_pkg::VALUE_W-1-k]};
      if (t >= cfg.radix) begin
        step_q[rde_pkg::STEP_BITS-1-k] = 1'b1;
        t = t - cfg.radix;
      end
      r = t[rde_pkg::DIGIT_W-1:0];
    end
    step_rem = r;
  end

  assign quot_next = {div_r[rde_pkg::VALUE_W-rde_pkg::STEP_BITS-1:0], step_q};
  assign cnt_m1    = cnt_r - 1'b1;

  // Sequencer: take a word, divide digit by digit, then emit.
  always_comb begin
    st_nxt        = st_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    buf_we        = 1'b0;
    unique case (st_r)
      rde_pkg::BK_IDLE: begin
        if (item.vld) begin
          pop      = 1'b1;
          div_nxt  = item.value;
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = rde_pkg::BK_DIV;
        end
      end
      rde_pkg::BK_DIV: begin
        div_nxt  = quot_next;
        rem_nxt  = step_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == rde_pkg::STEP_CNT_W'(rde_pkg::STEPS_PER_DIG - 1)) begin
          // One digit is complete; keep only the low MAX_DIGITS digits.
          buf_we  = (cnt_r < CNT_W'(MAX_DIGITS));
          cnt_nxt = buf_we ? cnt_r + 1'b1 : cnt_r;
          rem_nxt = '0;
          if (quot_next == '0) begin
            st_nxt = rde_pkg::BK_EMIT;
          end
        end
      end
      rde_pkg::BK_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cfg.chars[buf_r[cnt_m1[IDX_W-1:0]]];
          out_last_nxt  = (cnt_r == CNT_W'(1));
          cnt_nxt       = cnt_m1;
          if (cnt_r == CNT_W'(1)) begin
            st_nxt = rde_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        st_nxt = rde_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rde_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[cnt_r[IDX_W-1:0]] <= step_rem;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last_digit = out_last_r;

  assign stat.state    = st_r;
  assign stat.rem      = rem_r;
  assign stat.cnt_zero = (cnt_r == '0);

endmodule

FILE: rtl/radix_digit_emitter.sv
// Top level of the radix digit emitter: configuration registers, front end
// queue and back end converter. Depends on rde_pkg, rde_front and rde_back.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   in_value (32 bits)
//   out      output     out_valid / out_stall out_character, out_last_digit
//   cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// Division retires one dividend byte per cycle through eight restoring steps,
// and the buffered digits are then emitted most significant first.
// Reset is synchronous and active low; it restores the default base 16 table.
// A two-word queue keeps taking input while the back end works, until it is full,
// and the output register holds a stalled last character while the divider starts the next word.
module radix_digit_emitter #(
  parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rde_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rde_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last_digit,
  input  logic                          cfg_wr_en,
  input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rde_pkg::CFG_DW-1:0]    cfg_wdata
);

  logic [rde_pkg::RADIX_W-1:0] radix_r;
  logic [rde_pkg::CFG_DW-1:0]  chars_lo_r;
  logic [rde_pkg::CFG_DW-1:0]  chars_hi_r;
  rde_pkg::cfg_t               cfg;
  rde_pkg::fe_item_t           fe_item;
  rde_pkg::bk_stat_t           bk_stat;
  logic                        bk_pop;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= rde_pkg::RADIX_RST;
      chars_lo_r <= rde_pkg::CHARS_LO_RST;
      chars_hi_r <= rde_pkg::CHARS_HI_RST;
    end else if (cfg_wr_en) begin
      unique case (rde_pkg::cfg_idx_t'(cfg_index))
        rde_pkg::REG_RADIX:    radix_r    <= cfg_wdata[rde_pkg::RADIX_W-1:0];
        rde_pkg::REG_CHARS_LO: chars_lo_r <= cfg_wdata;
        rde_pkg::REG_CHARS_HI: chars_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.radix = radix_r;
  assign cfg.chars = {chars_hi_r, chars_lo_r};

  rde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .item     (fe_item),
    .pop      (bk_pop)
  );

  rde_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .item           (fe_item),
    .pop            (bk_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_character  (out_character),
    .out_last_digit (out_last_digit),
    .stat           (bk_stat)
  );

  // The partial remainder always stays below the base.
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.state == rde_pkg::BK_DIV |-> {1'b0, bk_stat.rem} < radix_r)
    else $error("division remainder reached the base");

  // Emission never starts or continues with an empty digit buffer.
  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.state == rde_pkg::BK_EMIT |-> !bk_stat.cnt_zero)
    else $error("emission with no buffered digits");

  // The back end only takes a word that the queue offers.
  a_pop_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> fe_item.vld)
    else $error("queue popped while empty");

  // A new word starts dividing right after it leaves the queue.
  a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |=> bk_stat.state == rde_pkg::BK_DIV)
    else $error("popped word did not start division");

endmodule
